// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define LGS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// consequent holds in the clock after the antecedent
`define LGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// constants shared by the linear glide slew block
// ----------------------------------------------------------------------------
package lgs_pkg;

	// ramp reciprocal register, unsigned Q1.23
	localparam int INV_W         = 24;
	localparam int INV_FRAC_BITS = 23;
	localparam logic [INV_W-1:0] INV_RESET = 24'd175;

endpackage

// File: hw/rtl/lgs_target_if.sv
// ----------------------------------------------------------------------------
// lgs_target_if
// request channel carrying target samples into the block
// ----------------------------------------------------------------------------
interface lgs_target_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] target_sample;

	modport source (output valid, output target_sample, input ready);
	modport sink   (input valid, input target_sample, output ready);
endinterface

// File: hw/rtl/lgs_glide_if.sv
// ----------------------------------------------------------------------------
// lgs_glide_if
// request channel carrying glided samples out of the block
// ----------------------------------------------------------------------------
interface lgs_glide_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] glided_sample;

	modport source (output valid, output glided_sample, input ready);
	modport sink   (input valid, input glided_sample, output ready);
endinterface

// File: hw/rtl/lgs_cfg_if.sv
// ----------------------------------------------------------------------------
// lgs_cfg_if
// write channel for the ramp reciprocal register
// ----------------------------------------------------------------------------
interface lgs_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [lgs_pkg::INV_W-1:0]  inverse_ramp;

	modport source (output valid, output inverse_ramp, input ready);
	modport sink   (input valid, input inverse_ramp, output ready);
endinterface

// File: hw/rtl/linear_glide_slew.sv
// ----------------------------------------------------------------------------
// linear_glide_slew
// linear glide (portamento) on a signed fixed-point sample stream
// ----------------------------------------------------------------------------
// Each target sample moves the output toward it in equal steps of
// (target - current) * inverse_ramp per sample, snapping to the target when
// it is reached or passed. The block takes one sample per clock unless
// stalled and returns one glided sample per request through its input and
// output registers. The rate is set by the update loop on the current value:
// one multiply, one saturating add and the snap compare. inverse_ramp resets
// to 175 (about one second at 48 kHz); write it through cfg only while no
// request is in flight, which the block does not enforce. cfg.ready is
// always high. Reset clears the current value and the stored target to zero.
// ----------------------------------------------------------------------------
module linear_glide_slew #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	lgs_target_if.sink    target,
	lgs_glide_if.source   glide,
	lgs_cfg_if.sink       cfg
);
	localparam int W = SAMPLE_BITS;

	logic [lgs_pkg::INV_W-1:0] inv_q;
	logic signed [W-1:0]       cur_q;
	logic signed [W-1:0]       end_q;
	logic signed [W:0]         step_q;
	logic                      active_q;

	logic signed [W-1:0]       target_s1;
	logic                      valid_s1;
	logic signed [W-1:0]       glided_q;
	logic                      out_valid_q;

	logic                      advance;
	logic signed [W-1:0]       next_cur;
	logic signed [W:0]         next_step;
	logic                      next_active;

	// handshakes
	assign advance      = valid_s1 & (~out_valid_q | glide.ready);
	assign target.ready = ~valid_s1 | advance;
	assign cfg.ready    = 1'b1;

	assign glide.valid         = out_valid_q;
	assign glide.glided_sample = glided_q;

	// ramp reciprocal register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= lgs_pkg::INV_RESET;
		end else if (cfg.valid) begin
			inv_q <= cfg.inverse_ramp;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (target.ready) begin
			valid_s1 <= target.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (target.valid && target.ready) begin
			target_s1 <= target.target_sample;
		end
	end

	// glide next-state logic
	lgs_update #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_update (
		.target      (target_s1),
		.inverse_ramp(inv_q),
		.cur         (cur_q),
		.end_target  (end_q),
		.step        (step_q),
		.active      (active_q),
		.next_cur    (next_cur),
		.next_step   (next_step),
		.next_active (next_active)
	);

	// glide state, updated once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			end_q    <= '0;
			step_q   <= '0;
			active_q <= 1'b0;
		end else if (advance) begin
			cur_q    <= next_cur;
			end_q    <= target_s1;
			step_q   <= next_step;
			active_q <= next_active;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (glide.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			glided_q <= next_cur;
		end
	end
endmodule

// File: hw/rtl/lgs_update.sv
// ----------------------------------------------------------------------------
// lgs_update
// next-state logic of the glide: step computation, saturating add, snap test
// ----------------------------------------------------------------------------
module lgs_update #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic signed [SAMPLE_BITS-1:0] target,
	input  logic [lgs_pkg::INV_W-1:0]     inverse_ramp,
	input  logic signed [SAMPLE_BITS-1:0] cur,
	input  logic signed [SAMPLE_BITS-1:0] end_target,
	input  logic signed [SAMPLE_BITS:0]   step,
	input  logic                          active,
	output logic signed [SAMPLE_BITS-1:0] next_cur,
	output logic signed [SAMPLE_BITS:0]   next_step,
	output logic                          next_active
);
	localparam int W  = SAMPLE_BITS;
	localparam int PW = W + 1 + lgs_pkg::INV_W;   // product width
	localparam int QW = PW - lgs_pkg::INV_FRAC_BITS;  // shifted product width

	localparam logic [QW-1:0]        P_ONE   = QW'(1);
	localparam logic [QW-1:0]        P_LIM   = QW'(1) << W;
	localparam logic signed [W:0]    STEP_MAX = {1'b0, {W{1'b1}}};
	localparam logic signed [W+1:0]  SUM_MAX  = {3'b000, {(W-1){1'b1}}};
	localparam logic signed [W+1:0]  SUM_MIN  = {3'b111, {(W-1){1'b0}}};

	logic                   new_tgt;
	logic signed [W:0]      diff;
	logic [W:0]             mag;
	logic [PW-1:0]          prod;
	logic [QW-1:0]          p_raw;
	logic [QW-1:0]          p_fix;
	logic signed [W:0]      step_calc;
	logic signed [W:0]      step_use;
	logic                   active_use;
	logic signed [W+1:0]    sum;
	logic signed [W-1:0]    sat;
	logic                   snap;

	// new target and distance to it
	assign new_tgt = (target != end_target);
	assign diff    = {target[W-1], target} - {cur[W-1], cur};
	assign mag     = diff[W] ? $unsigned(-diff) : $unsigned(diff);

	// step magnitude: truncated product, at least one lsb, at most 2^W
	assign prod  = PW'(mag) * PW'(inverse_ramp);
	assign p_raw = prod[PW-1:lgs_pkg::INV_FRAC_BITS];

	always_comb begin
		p_fix = p_raw;
		if (p_raw == '0) begin
			p_fix = P_ONE;
		end else if (p_raw > P_LIM) begin
			p_fix = P_LIM;
		end
	end

	// signed step, clamped to the step range
	always_comb begin
		if (mag == '0) begin
			step_calc = '0;
		end else if (diff[W]) begin
			step_calc = -$signed(p_fix[W:0]);
		end else if (p_fix == P_LIM) begin
			step_calc = STEP_MAX;
		end else begin
			step_calc = $signed(p_fix[W:0]);
		end
	end

	assign step_use   = new_tgt ? step_calc : step;
	assign active_use = new_tgt | active;

	// saturating add
	assign sum = (W+2)'(cur) + (W+2)'(step_use);

	always_comb begin
		if (sum > SUM_MAX) begin
			sat = SUM_MAX[W-1:0];
		end else if (sum < SUM_MIN) begin
			sat = SUM_MIN[W-1:0];
		end else begin
			sat = sum[W-1:0];
		end
	end

	// any change of the sign of (value - target) ends the ramp
	assign snap = ((cur > target) != (sat > target)) || ((cur < target) != (sat < target));

	// next state
	always_comb begin
		next_step   = step_use;
		next_active = active_use & ~snap;
		if (!active_use) begin
			next_cur = cur;
		end else if (snap) begin
			next_cur = target;
		end else begin
			next_cur = sat;
		end
	end
endmodule

// File: hw/rtl/lgs_checker.sv
// ----------------------------------------------------------------------------
// lgs_checker
// port-level checks of the linear glide slew block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lgs_checker #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   t_valid,
	input logic                   t_ready,
	input logic                   g_valid,
	input logic                   g_ready,
	input logic [SAMPLE_BITS-1:0] g_data
);
	// an empty output stage never back-pressures the input
	`LGS_ASSERT(a_ready_when_empty, clk, arst_n, !g_valid |-> t_ready, "input stalled with empty output")

	// a fresh result comes from a request that passed the input register
	`LGS_ASSERT(a_result_has_request, clk, arst_n, $rose(g_valid) |-> $past(t_valid && t_ready, 2), "result without request")

	// a stalled result stays offered
	`LGS_ASSERT_NEXT(a_valid_holds, clk, arst_n, g_valid && !g_ready, g_valid, "result dropped while stalled")

	// a stalled result keeps its value
	`LGS_ASSERT_NEXT(a_data_holds, clk, arst_n, g_valid && !g_ready, $stable(g_data), "result changed while stalled")
endmodule

bind linear_glide_slew lgs_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_lgs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.t_valid(target.valid),
	.t_ready(target.ready),
	.g_valid(glide.valid),
	.g_ready(glide.ready),
	.g_data (glide.glided_sample)
);
